>>> rtl/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// hrhp_pkg
// Types, constants and the per-byte parse functions shared by the request
// head parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hrhp_pkg;

  localparam int PosBits = 16;
  localparam int CntBits = 8;

  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_TARGET  = 3'd1,
    PH_VERSION = 3'd2,
    PH_NAME    = 3'd3,
    PH_VALUE   = 3'd4,
    PH_BODY    = 3'd5,
    PH_DONE    = 3'd6,
    PH_BAD     = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_PARTIAL   = 2'd0,
    ST_COMPLETE  = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  localparam logic [0:0] REG_HEAD_LIMIT   = 1'd0;
  localparam logic [0:0] REG_HEADER_LIMIT = 1'd1;

  localparam logic [2:0] KIND_CL   = 3'b001;
  localparam logic [2:0] KIND_TE   = 3'b010;
  localparam logic [2:0] KIND_CONN = 3'b100;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_QUERY = 8'h3f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // strings right-aligned in a 17 character field
  localparam logic [135:0] STR_VER   = 136'("HTTP/1.1");
  localparam logic [135:0] STR_CL    = 136'("content-length");
  localparam logic [135:0] STR_TE    = 136'("transfer-encoding");
  localparam logic [135:0] STR_CONN  = 136'("connection");
  localparam logic [135:0] STR_CLOSE = 136'("close");
  localparam logic [135:0] STR_KA    = 136'("keep-alive");

  localparam logic [PosBits-1:0] POS_MAX = {PosBits{1'b1}};
  localparam logic [CntBits-1:0] CNT_MAX = {CntBits{1'b1}};

  typedef struct packed {
    phase_t               phase;
    logic                 cr_pending;
    logic [PosBits-1:0]   byte_position;
    logic [15:0]          method_count;
    logic [15:0]          target_count;
    logic [15:0]          path_count;
    logic                 query_seen;
    logic [3:0]           version_index;
    logic                 version_minor_one;
    logic [CntBits-1:0]   header_total;
    logic [15:0]          name_count;
    logic                 name_last_blank;
    logic [2:0]           name_match_bits;
    logic [1:0]           value_match_bits;
    logic [4:0]           value_index;
    logic                 value_blank_pending;
    logic [4:0]           digit_count;
    logic [63:0]          digit_value;
    logic                 length_seen;
    logic [63:0]          declared_length;
    logic                 persist_flag;
    logic [63:0]          body_remaining;
    logic [PosBits-1:0]   head_end;
    logic [63:0]          total_sum;
  } parse_state_t;

  typedef struct packed {
    logic [15:0]        head_limit;
    logic [CntBits-1:0] header_limit;
  } limits_t;

  function automatic parse_state_t clear_state();
    parse_state_t s;
    s = '0;
    s.phase = PH_METHOD;
    s.name_match_bits = 3'b111;
    s.value_match_bits = 2'b11;
    return s;
  endfunction

  function automatic logic [7:0] char_at(logic [135:0] str, logic [4:0] n, logic [4:0] i);
    logic [7:0] sh;
    sh = 8'({3'd0, n} - 8'd1 - {3'd0, i}) << 3;
    return str[sh +: 8];
  endfunction

  function automatic logic [7:0] lower(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SP || c == CH_TAB;
  endfunction

  function automatic logic [15:0] inc16(logic [15:0] v);
    return (v != 16'hffff) ? v + 16'd1 : v;
  endfunction

  function automatic logic keep(logic live, logic [135:0] str, logic [4:0] n,
                                logic [15:0] idx, logic [7:0] c);
    return live && idx < {11'd0, n} && char_at(str, n, idx[4:0]) == c;
  endfunction

  function automatic logic in_head(phase_t p);
    return p == PH_METHOD || p == PH_TARGET || p == PH_VERSION ||
           p == PH_NAME || p == PH_VALUE;
  endfunction

  function automatic parse_state_t start_line(parse_state_t si);
    parse_state_t s;
    s = si;
    s.phase = PH_NAME;
    s.name_count = '0;
    s.name_last_blank = 1'b0;
    s.name_match_bits = 3'b111;
    return s;
  endfunction

  function automatic parse_state_t content(parse_state_t si, logic [7:0] c,
                                           logic [CntBits-1:0] hdr_limit);
    parse_state_t s;
    logic [7:0]  l;
    logic [2:0]  k;
    logic [67:0] prod;
    s = si;
    l = lower(c);
    k = '0;
    prod = ({4'd0, s.digit_value} << 3) + ({4'd0, s.digit_value} << 1)
         + {60'd0, c - CH_ZERO};
    case (s.phase)
      PH_METHOD: begin
        if (c == CH_SP) s.phase = (s.method_count == '0) ? PH_BAD : PH_TARGET;
        else s.method_count = inc16(s.method_count);
      end
      PH_TARGET: begin
        if (c == CH_SP) begin
          if (s.target_count == '0) s.phase = PH_BAD;
          else begin
            s.phase = PH_VERSION;
            s.version_index = '0;
          end
        end else begin
          s.target_count = inc16(s.target_count);
          if (c == CH_QUERY && !s.query_seen) s.query_seen = 1'b1;
          else if (!s.query_seen) s.path_count = inc16(s.path_count);
        end
      end
      PH_VERSION: begin
        if (s.version_index >= 4'd8) s.phase = PH_BAD;
        else if (s.version_index == 4'd7) begin
          if (c == CH_ONE || c == CH_ZERO) begin
            s.version_minor_one = (c == CH_ONE);
            s.version_index = s.version_index + 4'd1;
          end else s.phase = PH_BAD;
        end else if (c != char_at(STR_VER, 5'd8, {1'b0, s.version_index})) begin
          s.phase = PH_BAD;
        end else s.version_index = s.version_index + 4'd1;
      end
      PH_NAME: begin
        if (c == CH_COLON) begin
          if (s.name_count == '0 || s.name_last_blank || s.header_total >= hdr_limit) begin
            s.phase = PH_BAD;
          end else begin
            if (s.header_total != CNT_MAX) s.header_total = s.header_total + 1'b1;
            if (s.name_match_bits[0] && s.name_count == 16'd14) k = KIND_CL;
            else if (s.name_match_bits[1] && s.name_count == 16'd17) k = KIND_TE;
            else if (s.name_match_bits[2] && s.name_count == 16'd10) k = KIND_CONN;
            if (k == KIND_TE) s.phase = PH_BAD;
            else begin
              s.name_match_bits = k;
              s.phase = PH_VALUE;
              s.value_match_bits = 2'b11;
              s.value_index = '0;
              s.value_blank_pending = 1'b0;
              s.digit_count = '0;
              s.digit_value = '0;
            end
          end
        end else begin
          s.name_match_bits[0] = keep(si.name_match_bits[0], STR_CL, 5'd14, si.name_count, l);
          s.name_match_bits[1] = keep(si.name_match_bits[1], STR_TE, 5'd17, si.name_count, l);
          s.name_match_bits[2] = keep(si.name_match_bits[2], STR_CONN, 5'd10, si.name_count,
                                      l);
          s.name_count = inc16(s.name_count);
          s.name_last_blank = is_blank(c);
        end
      end
      PH_VALUE: begin
        if (s.name_match_bits == KIND_CL) begin
          if (is_blank(c)) begin
            if (s.digit_count != '0) s.value_blank_pending = 1'b1;
          end else if (s.value_blank_pending || c < CH_ZERO || c > CH_NINE ||
                       s.digit_count >= 5'd20 || prod[67:64] != 4'd0) begin
            s.phase = PH_BAD;
          end else begin
            s.digit_value = prod[63:0];
            s.digit_count = s.digit_count + 5'd1;
          end
        end else if (s.name_match_bits == KIND_CONN) begin
          if (is_blank(c)) begin
            if (s.value_index != '0) s.value_blank_pending = 1'b1;
          end else begin
            if (s.value_blank_pending) s.value_match_bits = '0;
            s.value_match_bits[0] = keep(s.value_match_bits[0], STR_CLOSE, 5'd5,
                                         {11'd0, s.value_index}, l);
            s.value_match_bits[1] = keep(s.value_match_bits[1], STR_KA, 5'd10,
                                         {11'd0, s.value_index}, l);
            if (s.value_index != 5'd31) s.value_index = s.value_index + 5'd1;
          end
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic parse_state_t end_line(parse_state_t si);
    parse_state_t s;
    logic [64:0]  sum;
    s = si;
    sum = {1'b0, s.declared_length} + {{(65-PosBits){1'b0}}, s.byte_position};
    case (s.phase)
      PH_VERSION: begin
        if (s.version_index != 4'd8) s.phase = PH_BAD;
        else begin
          s.persist_flag = s.version_minor_one;
          s = start_line(s);
        end
      end
      PH_NAME: begin
        if (s.name_count != '0) s.phase = PH_BAD;
        else begin
          s.head_end = s.byte_position;
          if (sum[64]) s.phase = PH_BAD;
          else begin
            s.total_sum = sum[63:0];
            s.body_remaining = s.declared_length;
            s.phase = (s.declared_length != '0) ? PH_BODY : PH_DONE;
          end
        end
      end
      PH_VALUE: begin
        if (s.name_match_bits == KIND_CL) begin
          if (s.digit_count == '0 ||
              (s.length_seen && s.digit_value != s.declared_length)) begin
            s.phase = PH_BAD;
          end else begin
            s.declared_length = s.digit_value;
            s.length_seen = 1'b1;
            s = start_line(s);
          end
        end else begin
          if (s.name_match_bits == KIND_CONN) begin
            if (s.value_match_bits[0] && s.value_index == 5'd5) s.persist_flag = 1'b0;
            else if (s.value_match_bits[1] && s.value_index == 5'd10) s.persist_flag = 1'b1;
          end
          s = start_line(s);
        end
      end
      default: s.phase = PH_BAD;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/http_request_head_parser_core.sv
// ----------------------------------------------------------------------------
// http_request_head_parser_core
// Streaming request head checker: one byte in, one status word out.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     in_valid / in_ready     data_byte, first_byte
//  output    out_valid / out_ready   status .. total_len
//  config    cfg_write               cfg_index, cfg_data
//
//  one request byte per cycle sustained while results are taken; each result
//  is registered: the input register feeds the step logic, whose output
//  loads the result register
//  the parse state advances in the same cycle the result register loads
//  synchronous reset clears control and the parse state, and loads default limits
//  a stalled output holds both stages; the input stage refills as soon as
//  the result is taken
`default_nettype none

module http_request_head_parser_core (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        in_valid,
  output logic              in_ready,
  input  wire  logic [7:0]  data_byte,
  input  wire  logic        first_byte,
  output logic              out_valid,
  input  wire  logic        out_ready,
  output logic [1:0]        status,
  output logic [15:0]       method_bytes,
  output logic [15:0]       target_bytes,
  output logic [15:0]       path_bytes,
  output logic              is_http11,
  output logic              conn_persist,
  output logic [7:0]        header_count,
  output logic [63:0]       body_length,
  output logic [15:0]       body_offset,
  output logic [63:0]       total_len,
  input  wire  logic        cfg_write,
  input  wire  logic [0:0]  cfg_index,
  input  wire  logic [15:0] cfg_data
);

  // configuration limits
  hrhp_pkg::limits_t limits;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_first;

  // parse state
  hrhp_pkg::parse_state_t state;
  hrhp_pkg::parse_state_t state_next;

  logic advance;

  // result register moves when empty or being taken
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.head_limit   <= 16'd8192;
      limits.header_limit <= 8'd32;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hrhp_pkg::REG_HEAD_LIMIT:   limits.head_limit <= cfg_data;
        hrhp_pkg::REG_HEADER_LIMIT: limits.header_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte  <= data_byte;
      s1_first <= first_byte;
    end
  end

  hrhp_step u_step (
    .cur        (state),
    .data_byte  (s1_byte),
    .first_byte (s1_first),
    .limits     (limits),
    .nxt        (state_next)
  );

  // state and result register load together when a request byte moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hrhp_pkg::clear_state();
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) state <= state_next;
    end
  end

  always_comb begin
    unique case (state.phase)
      hrhp_pkg::PH_BAD:  status = hrhp_pkg::ST_MALFORMED;
      hrhp_pkg::PH_DONE: status = hrhp_pkg::ST_COMPLETE;
      default:           status = hrhp_pkg::ST_PARTIAL;
    endcase
  end

  assign method_bytes = state.method_count;
  assign target_bytes = state.target_count;
  assign path_bytes   = state.path_count;
  assign is_http11    = state.version_minor_one;
  assign conn_persist = state.persist_flag;
  assign header_count = state.header_total;
  assign body_length  = state.declared_length;
  assign body_offset  = state.head_end;
  assign total_len    = (state.phase == hrhp_pkg::PH_DONE) ? state.total_sum : 64'd0;

  // a held input byte is never lost while the result stage is stalled
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid)
    else $error("input stage dropped a request byte");

  // total length only shows on a complete request
  a_total_complete: assert property (@(posedge clk) disable iff (rst)
    (out_valid && total_len != 64'd0) |-> status == hrhp_pkg::ST_COMPLETE)
    else $error("total length outside complete status");

  // reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_valid))
    else $error("stages not empty after reset");

  // a complete request always carries the offset of its body
  a_done_offset: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == hrhp_pkg::ST_COMPLETE) |-> body_offset != 16'd0)
    else $error("complete request without body offset");

endmodule

`default_nettype wire

>>> rtl/hrhp_step.sv
// ----------------------------------------------------------------------------
// hrhp_step
// Next parse state for one request byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhp_step (
  input  wire hrhp_pkg::parse_state_t cur,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   first_byte,
  input  wire hrhp_pkg::limits_t      limits,
  output hrhp_pkg::parse_state_t      nxt
);

  hrhp_pkg::parse_state_t s0;

  always_comb begin
    logic handled;
    hrhp_pkg::parse_state_t s;
    s0 = first_byte ? hrhp_pkg::clear_state() : cur;
    s = s0;
    handled = 1'b0;
    if (s.phase == hrhp_pkg::PH_BODY) begin
      s.body_remaining = s.body_remaining - 64'd1;
      if (s.body_remaining == '0) s.phase = hrhp_pkg::PH_DONE;
    end else if (hrhp_pkg::in_head(s.phase)) begin
      if (s.byte_position >= limits.head_limit) begin
        s.phase = hrhp_pkg::PH_BAD;
      end else begin
        if (s.byte_position != hrhp_pkg::POS_MAX) s.byte_position = s.byte_position + 1'b1;
        // held-back cr: either a line end or a plain content byte
        if (s.cr_pending) begin
          s.cr_pending = 1'b0;
          if (data_byte == hrhp_pkg::CH_LF) begin
            s = hrhp_pkg::end_line(s);
            handled = 1'b1;
          end else begin
            s = hrhp_pkg::content(s, hrhp_pkg::CH_CR, limits.header_limit);
            if (!hrhp_pkg::in_head(s.phase)) handled = 1'b1;
          end
        end
        if (!handled) begin
          if (data_byte == hrhp_pkg::CH_CR) s.cr_pending = 1'b1;
          else if (data_byte == hrhp_pkg::CH_LF) s = hrhp_pkg::end_line(s);
          else s = hrhp_pkg::content(s, data_byte, limits.header_limit);
        end
      end
    end
    nxt = s;
  end

endmodule

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// request head parser testbench
// Drives request byte streams into the parser core, predicts each status word
// in a behavioural parser (or takes it typed in) and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  // result word as the parser reports it
  typedef struct {
    logic [1:0]  st;
    logic [15:0] mlen;
    logic [15:0] tlen;
    logic [15:0] plen;
    logic        v11;
    logic        ka;
    logic [7:0]  hcnt;
    logic [63:0] blen;
    logic [15:0] boff;
    logic [63:0] total;
  } report_t;

  // one directed stimulus row; chk marks a row whose status is typed in
  typedef struct {
    logic [7:0] b;
    logic       fb;
    logic       chk;
    logic [1:0] st;
  } row_t;

  localparam int WatchdogLimit = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        first_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [15:0] method_bytes, target_bytes, path_bytes;
  logic        is_http11, conn_persist;
  logic [7:0]  header_count;
  logic [63:0] body_length;
  logic [15:0] body_offset;
  logic [63:0] total_len;
  logic        cfg_write = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  always #1 clk = ~clk;

  http_request_head_parser_core dut (.*);

  // predictor state
  hrhp_pkg::phase_t ph;
  logic        crp, qseen, vminor, lenseen, persist, vblank, nblank;
  logic [15:0] pos, mcnt, tcnt, pcnt, ncnt, hend, lim_head;
  logic [3:0]  vidx;
  logic [7:0]  htot, lim_hdr;
  logic [2:0]  nbits;
  logic [1:0]  vbits;
  logic [4:0]  vi, dcnt;
  logic [63:0] dval, declen, bodyrem;

  string   ver_text = "HTTP/1.1";
  report_t expected_reports[$];
  int      mismatches = 0;
  int      idle_pct = 16;
  bit      hold_rx = 1'b0;
  int      quiet = 0;

  function automatic logic [7:0] fold(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic bit blank_ch(logic [7:0] c);
    return c == " " || c == "\t";
  endfunction

  function automatic logic [15:0] sat16(logic [15:0] v);
    return v == 16'hffff ? v : v + 16'd1;
  endfunction

  function automatic bit still_live(bit live, string s, int idx, logic [7:0] c);
    return live && idx < s.len() && s[idx] == c;
  endfunction

  function automatic void parse_reset();
    ph = hrhp_pkg::PH_METHOD; crp = 0; pos = 0; mcnt = 0; tcnt = 0; pcnt = 0; qseen = 0;
    vidx = 0; vminor = 0; htot = 0; ncnt = 0; nblank = 0; nbits = 3'b111;
    vbits = 2'b11; vi = 0; vblank = 0; dcnt = 0; dval = 0; lenseen = 0;
    declen = 0; persist = 0; bodyrem = 0; hend = 0;
  endfunction

  function automatic void new_header_line();
    ph = hrhp_pkg::PH_NAME; ncnt = 0; nblank = 0; nbits = 3'b111;
  endfunction

  function automatic void take_content(logic [7:0] c);
    logic [2:0]  k;
    logic [67:0] prod;
    k = '0;
    case (ph)
      hrhp_pkg::PH_METHOD: begin
        if (c == " ") ph = (mcnt == 0) ? hrhp_pkg::PH_BAD : hrhp_pkg::PH_TARGET;
        else mcnt = sat16(mcnt);
      end
      hrhp_pkg::PH_TARGET: begin
        if (c == " ") begin
          if (tcnt == 0) ph = hrhp_pkg::PH_BAD;
          else begin
            ph = hrhp_pkg::PH_VERSION; vidx = 0;
          end
        end else begin
          tcnt = sat16(tcnt);
          if (c == "?" && !qseen) qseen = 1;
          else if (!qseen) pcnt = sat16(pcnt);
        end
      end
      hrhp_pkg::PH_VERSION: begin
        if (vidx >= 8) ph = hrhp_pkg::PH_BAD;
        else if (vidx == 7) begin
          if (c == "1" || c == "0") begin
            vminor = (c == "1"); vidx++;
          end else ph = hrhp_pkg::PH_BAD;
        end else if (c != ver_text[vidx]) ph = hrhp_pkg::PH_BAD;
        else vidx++;
      end
      hrhp_pkg::PH_NAME: begin
        if (c == ":") begin
          if (ncnt == 0 || nblank || htot >= lim_hdr) ph = hrhp_pkg::PH_BAD;
          else begin
            if (htot != 8'hff) htot++;
            if (nbits[0] && ncnt == 14) k = hrhp_pkg::KIND_CL;
            else if (nbits[1] && ncnt == 17) k = hrhp_pkg::KIND_TE;
            else if (nbits[2] && ncnt == 10) k = hrhp_pkg::KIND_CONN;
            if (k == hrhp_pkg::KIND_TE) ph = hrhp_pkg::PH_BAD;
            else begin
              nbits = k; ph = hrhp_pkg::PH_VALUE; vbits = 2'b11; vi = 0; vblank = 0;
              dcnt = 0; dval = 0;
            end
          end
        end else begin
          nbits[0] = still_live(nbits[0], "content-length", ncnt, fold(c));
          nbits[1] = still_live(nbits[1], "transfer-encoding", ncnt, fold(c));
          nbits[2] = still_live(nbits[2], "connection", ncnt, fold(c));
          ncnt = sat16(ncnt);
          nblank = blank_ch(c);
        end
      end
      hrhp_pkg::PH_VALUE: begin
        if (nbits == hrhp_pkg::KIND_CL) begin
          prod = 68'(dval) * 10 + (c - 8'd48);
          if (blank_ch(c)) begin
            if (dcnt != 0) vblank = 1;
          end else if (vblank || c < "0" || c > "9" || dcnt >= 20 || prod[67:64] != 0)
            ph = hrhp_pkg::PH_BAD;
          else begin
            dval = prod[63:0]; dcnt++;
          end
        end else if (nbits == hrhp_pkg::KIND_CONN) begin
          if (blank_ch(c)) begin
            if (vi != 0) vblank = 1;
          end else begin
            if (vblank) vbits = 0;
            vbits[0] = still_live(vbits[0], "close", vi, fold(c));
            vbits[1] = still_live(vbits[1], "keep-alive", vi, fold(c));
            if (vi != 31) vi++;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void take_line_end();
    case (ph)
      hrhp_pkg::PH_VERSION: begin
        if (vidx != 8) ph = hrhp_pkg::PH_BAD;
        else begin
          persist = vminor; new_header_line();
        end
      end
      hrhp_pkg::PH_NAME: begin
        if (ncnt != 0) ph = hrhp_pkg::PH_BAD;
        else begin
          hend = pos;
          if (declen > 64'hffff_ffff_ffff_ffff - pos) ph = hrhp_pkg::PH_BAD;
          else begin
            bodyrem = declen;
            ph = declen != 0 ? hrhp_pkg::PH_BODY : hrhp_pkg::PH_DONE;
          end
        end
      end
      hrhp_pkg::PH_VALUE: begin
        if (nbits == hrhp_pkg::KIND_CL) begin
          if (dcnt == 0 || (lenseen && dval != declen)) ph = hrhp_pkg::PH_BAD;
          else begin
            declen = dval; lenseen = 1; new_header_line();
          end
        end else begin
          if (nbits == hrhp_pkg::KIND_CONN) begin
            if (vbits[0] && vi == 5) persist = 0;
            else if (vbits[1] && vi == 10) persist = 1;
          end
          new_header_line();
        end
      end
      default: ph = hrhp_pkg::PH_BAD;
    endcase
  endfunction

  // advances the parser by one request byte and returns the status word
  function automatic report_t parse_byte(logic [7:0] b, logic fb);
    report_t r;
    bit      done_cr;
    if (fb) parse_reset();
    if (ph == hrhp_pkg::PH_BODY) begin
      bodyrem--;
      if (bodyrem == 0) ph = hrhp_pkg::PH_DONE;
    end else if (hrhp_pkg::in_head(ph)) begin
      if (pos >= lim_head) ph = hrhp_pkg::PH_BAD;
      else begin
        pos = sat16(pos);
        done_cr = 0;
        if (crp) begin
          crp = 0;
          if (b == "\n") begin
            take_line_end(); done_cr = 1;
          end else begin
            take_content("\r");
            if (!hrhp_pkg::in_head(ph)) done_cr = 1;
          end
        end
        if (!done_cr) begin
          if (b == "\r") crp = 1;
          else if (b == "\n") take_line_end();
          else take_content(b);
        end
      end
    end
    r.st = ph == hrhp_pkg::PH_BAD ? hrhp_pkg::ST_MALFORMED :
           (ph == hrhp_pkg::PH_DONE ? hrhp_pkg::ST_COMPLETE : hrhp_pkg::ST_PARTIAL);
    r.mlen = mcnt; r.tlen = tcnt; r.plen = pcnt; r.v11 = vminor; r.ka = persist;
    r.hcnt = htot; r.blen = declen; r.boff = hend;
    r.total = ph == hrhp_pkg::PH_DONE ? 64'(hend) + declen : 0;
    return r;
  endfunction

  // send one request byte and queue its predicted status word
  task automatic send_byte(logic [7:0] b, logic fb, bit typed = 0,
                           logic [1:0] typed_st = hrhp_pkg::ST_PARTIAL);
    report_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    r = parse_byte(b, fb);
    if (typed) r.st = typed_st;
    in_valid <= 1'b1; data_byte <= b; first_byte <= fb;
    do @(posedge clk); while (!in_ready);
    expected_reports.push_back(r);
  endtask

  task automatic send_text(string s, bit fresh = 1);
    foreach (s[i]) send_byte(s[i], fresh && i == 0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(logic [15:0] hl, logic [7:0] hdl);
    cfg_write <= 1'b1; cfg_index <= hrhp_pkg::REG_HEAD_LIMIT; cfg_data <= hl;
    @(posedge clk);
    cfg_index <= hrhp_pkg::REG_HEADER_LIMIT; cfg_data <= {8'd0, hdl};
    @(posedge clk);
    cfg_write <= 1'b0;
    lim_head = hl; lim_hdr = hdl;
  endtask

  // random request: mostly well formed, with random content and some damage
  task automatic random_request();
    string s, meth, tgt, ver;
    int    n;
    if ($urandom_range(1)) meth = "GET";
    else meth = "POST";
    if ($urandom_range(1)) ver = " HTTP/1.1";
    else ver = " HTTP/1.0";
    tgt = "/";
    n = $urandom_range(6);
    repeat (n) tgt = {tgt, string'(8'($urandom_range(97, 122)))};
    if ($urandom_range(1)) tgt = {tgt, "?a=1?b"};
    s = {meth, " ", tgt, ver, "\r\n"};
    n = $urandom_range(3);
    repeat (n) begin
      case ($urandom_range(6))
        0: s = {s, "Host: x\r\n"};
        1: s = {s, "Content-Length: ", $sformatf("%0d", $urandom_range(4)), "\r\n"};
        2: s = {s, "connection: close\n"};
        3: s = {s, "Connection: Keep-Alive\r\n"};
        4: s = {s, "Transfer-Encoding: x\r\n"};
        5: s = {s, "X-a\t: b\r\n"};
        default: s = {s, "CONTENT-LENGTH: 99999999999999999999\r\n"};
      endcase
    end
    s = {s, "\r\n"};
    if ($urandom_range(9) == 0) s[$urandom_range(s.len() - 1)] = 8'($urandom);
    send_text(s);
    // trailing body bytes or noise, all random in value
    n = $urandom_range(4);
    repeat (n) send_byte(8'($urandom), 1'b0);
  endtask

  // result side
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result, status %0d", status);
        end else begin
          report_t e;
          e = expected_reports.pop_front();
          if (status !== e.st || method_bytes !== e.mlen || target_bytes !== e.tlen ||
              path_bytes !== e.plen || is_http11 !== e.v11 || conn_persist !== e.ka ||
              header_count !== e.hcnt || body_length !== e.blen ||
              body_offset !== e.boff || total_len !== e.total) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display({"mismatch: exp st=%0d m=%0d t=%0d p=%0d v=%0d k=%0d h=%0d",
                        " bl=%0d bo=%0d tl=%0d"},
                       e.st, e.mlen, e.tlen, e.plen, e.v11, e.ka, e.hcnt, e.blen,
                       e.boff, e.total);
              $display({"          got st=%0d m=%0d t=%0d p=%0d v=%0d k=%0d h=%0d",
                        " bl=%0d bo=%0d tl=%0d"},
                       status, method_bytes, target_bytes, path_bytes, is_http11,
                       conn_persist, header_count, body_length, body_offset, total_len);
            end
          end
        end
      end
      out_ready <= !hold_rx && ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchdogLimit) begin
      $display("http_request_head_parser_core test failed");
      $finish;
    end
  end

  row_t rows[$];

  task automatic add_rows(string s, logic [1:0] last_st, bit typed);
    foreach (s[i]) rows.push_back('{s[i], i == 0, typed && i == s.len() - 1, last_st});
  endtask

  initial begin
    parse_reset();
    lim_head = 16'd8192; lim_hdr = 8'd32;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: extremes, every header kind and the special cases
    add_rows("GET / HTTP/1.1\r\n\r\n", hrhp_pkg::ST_COMPLETE, 1);
    add_rows(" ", hrhp_pkg::ST_MALFORMED, 1);
    add_rows("G  ", hrhp_pkg::ST_MALFORMED, 1);
    add_rows("A b HTTP/2", hrhp_pkg::ST_MALFORMED, 1);
    add_rows("A b HTTP/1.11", hrhp_pkg::ST_MALFORMED, 1);
    add_rows("P /a?b?c HTTP/1.0\nConnection: keep-alive\nContent-Length: 2\n\nxyZZ",
             hrhp_pkg::ST_COMPLETE, 0);
    add_rows("A / HTTP/1.1\r\nTransfer-Encoding:", hrhp_pkg::ST_MALFORMED, 1);
    add_rows("A / HTTP/1.1\r\n:", hrhp_pkg::ST_MALFORMED, 1);
    add_rows("A / HTTP/1.1\r\nx \r\n", hrhp_pkg::ST_MALFORMED, 1);
    add_rows("A / HTTP/1.1\r\nContent-Length: 1x", hrhp_pkg::ST_MALFORMED, 1);
    add_rows("A / HTTP/1.1\nContent-Length: 18446744073709551615\n\n",
             hrhp_pkg::ST_MALFORMED, 1);
    add_rows("A / HTTP/1.1\nContent-Length: 18446744073709551616",
             hrhp_pkg::ST_MALFORMED, 1);
    add_rows("A / HTTP/1.1\nContent-Length: 000000000000000000001",
             hrhp_pkg::ST_MALFORMED, 1);
    add_rows("A / HTTP/1.1\nContent-Length: 1\ncontent-length: 2\n",
             hrhp_pkg::ST_MALFORMED, 1);
    add_rows("A /\r HTTP/1.1\nconnection: close\n\r\n", hrhp_pkg::ST_COMPLETE, 0);
    foreach (rows[i]) send_byte(rows[i].b, rows[i].fb, rows[i].chk, rows[i].st);
    drain();

    // limits at their extremes, then a sweep of byte values
    set_limits(16'd64, 8'd1);
    send_text("GET /0123456789012345678901234567890123456789 HTTP/1.1\r\nA: b\r\n\r\n");
    send_text("GET / HTTP/1.1\r\nA: b\r\nB: c\r\n\r\n");
    for (int v = 0; v < 256; v += 16) send_byte(8'(v), v == 0);
    drain();
    set_limits(16'hffff, 8'd255);
    repeat (2) send_text("GET / HTTP/1.1\r\nX: y\r\n\r\n");
    drain();
    set_limits(16'd8192, 8'd0);
    send_text("GET / HTTP/1.1\r\nX: y\r\n\r\n");
    drain();
    set_limits(16'd200, 8'd3);

    // receiver held off while the sender keeps offering bytes
    fork
      begin
        hold_rx = 1'b1;
        repeat (60) @(posedge clk);
        hold_rx = 1'b0;
      end
      random_request();
    join
    drain();

    // random part, with a stretch of no idling in the middle
    for (int i = 0; i < 4; i++) begin
      idle_pct = (i >= 1 && i < 3) ? 0 : 16;
      random_request();
      if (i == 1) drain();
    end
    idle_pct = 16;
    drain();

    if (mismatches == 0 && expected_reports.size() == 0)
      $display("http_request_head_parser_core test passed");
    else
      $display("http_request_head_parser_core test failed");
    $finish;
  end

endmodule
